// ===== hw/rtl/rmmcs_pkg.sv =====
// Shared constants, types and helper functions of the RGB min/max contrast stretch core.
package rmmcs_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int IN_BITS         = 16;
    localparam int OUT_BITS        = 8;
    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES      = OUT_BITS / STEPS_PER_STAGE;
    localparam int PIPE_STAGES     = DIV_STAGES + 2;
    localparam int CFG_INDEX_BITS  = 3;
    localparam int CFG_DATA_BITS   = 16;

    localparam logic [OUT_BITS-1:0] ALPHA_OPAQUE = '1;
    localparam logic [OUT_BITS-1:0] ALPHA_CLEAR  = '0;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [OUT_BITS-1:0]    pixel_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_RED_LOW    = 3'd0,
        REG_RED_HIGH   = 3'd1,
        REG_GREEN_LOW  = 3'd2,
        REG_GREEN_HIGH = 3'd3,
        REG_BLUE_LOW   = 3'd4,
        REG_BLUE_HIGH  = 3'd5,
        REG_ALPHA_MODE = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        sample_t low;
        sample_t high;
    } window_t;

    typedef struct packed {
        window_t red;
        window_t green;
        window_t blue;
        logic    alpha_mode;
    } cfg_t;

    // Per-channel divider state as it moves down the pipeline.
    typedef struct packed {
        logic    zero;
        logic    sat;
        sample_t rem;
        sample_t span;
        pixel_t  quot;
    } lane_t;

    // One restoring division step: doubles the remainder and retires one quotient bit.
    function automatic lane_t div_step(lane_t x);
        logic [SAMPLE_BITS:0] shifted;
        logic [SAMPLE_BITS:0] trial;
        lane_t                y;
        shifted = {x.rem, 1'b0};
        trial   = shifted - {1'b0, x.span};
        y       = x;
        if (!trial[SAMPLE_BITS])
        begin
            y.rem  = trial[SAMPLE_BITS-1:0];
            y.quot = {x.quot[OUT_BITS-2:0], 1'b1};
        end
        else
        begin
            y.rem  = shifted[SAMPLE_BITS-1:0];
            y.quot = {x.quot[OUT_BITS-2:0], 1'b0};
        end
        return y;
    endfunction

    // Final channel value: below window, saturated, or the quotient.
    function automatic pixel_t lane_value(lane_t x);
        pixel_t v;
        if (x.zero)
        begin
            v = '0;
        end
        else if (x.sat)
        begin
            v = '1;
        end
        else
        begin
            v = x.quot;
        end
        return v;
    endfunction

endpackage

// ===== hw/rtl/rmmcs_cfg_regs.sv =====
// Configuration register file holding the three stretch windows and the alpha mode.
module rmmcs_cfg_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [rmmcs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [rmmcs_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output rmmcs_pkg::cfg_t                      cfg
);

    rmmcs_pkg::cfg_t cfg_reg;
    rmmcs_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (rmmcs_pkg::cfg_reg_t'(cfg_index))
                rmmcs_pkg::REG_RED_LOW:    cfg_next.red.low    = cfg_data[rmmcs_pkg::SAMPLE_BITS-1:0];
                rmmcs_pkg::REG_RED_HIGH:   cfg_next.red.high   = cfg_data[rmmcs_pkg::SAMPLE_BITS-1:0];
                rmmcs_pkg::REG_GREEN_LOW:  cfg_next.green.low  = cfg_data[rmmcs_pkg::SAMPLE_BITS-1:0];
                rmmcs_pkg::REG_GREEN_HIGH: cfg_next.green.high = cfg_data[rmmcs_pkg::SAMPLE_BITS-1:0];
                rmmcs_pkg::REG_BLUE_LOW:   cfg_next.blue.low   = cfg_data[rmmcs_pkg::SAMPLE_BITS-1:0];
                rmmcs_pkg::REG_BLUE_HIGH:  cfg_next.blue.high  = cfg_data[rmmcs_pkg::SAMPLE_BITS-1:0];
                rmmcs_pkg::REG_ALPHA_MODE: cfg_next.alpha_mode = cfg_data[0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.red.low      <= '0;
            cfg_reg.red.high     <= '1;
            cfg_reg.green.low    <= '0;
            cfg_reg.green.high   <= '1;
            cfg_reg.blue.low     <= '0;
            cfg_reg.blue.high    <= '1;
            cfg_reg.alpha_mode   <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/rmmcs_lane.sv =====
// One channel of the stretch: window compare stage followed by a pipelined restoring divider.
module rmmcs_lane (
    input  logic                               clk,
    input  logic [rmmcs_pkg::DIV_STAGES:0]     en,
    input  rmmcs_pkg::sample_t                 sample,
    input  rmmcs_pkg::window_t                 window,
    output rmmcs_pkg::lane_t                   result
);

    localparam int SB = rmmcs_pkg::SAMPLE_BITS;

    rmmcs_pkg::lane_t stage_reg [rmmcs_pkg::DIV_STAGES+1];
    rmmcs_pkg::lane_t front_next;

    logic [SB:0] diff;
    logic [SB:0] span;
    logic        below;
    logic        empty;
    logic        over;

    // The quotient reaches 256 exactly when the offset is at least the span.
    always_comb
    begin
        diff  = {1'b0, sample} - {1'b0, window.low};
        span  = {1'b0, window.high} - {1'b0, window.low};
        below = diff[SB];
        empty = span[SB] || (span[SB-1:0] == '0);
        over  = (diff[SB-1:0] >= span[SB-1:0]);
        front_next.zero = below;
        front_next.sat  = !below && (empty || over);
        front_next.rem  = diff[SB-1:0];
        front_next.span = span[SB-1:0];
        front_next.quot = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            stage_reg[0] <= front_next;
        end
    end

    for (genvar k = 1; k <= rmmcs_pkg::DIV_STAGES; k++)
    begin : g_div
        rmmcs_pkg::lane_t step_val [rmmcs_pkg::STEPS_PER_STAGE+1];

        assign step_val[0] = stage_reg[k-1];

        for (genvar j = 0; j < rmmcs_pkg::STEPS_PER_STAGE; j++)
        begin : g_step
            assign step_val[j+1] = rmmcs_pkg::div_step(step_val[j]);
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                stage_reg[k] <= step_val[rmmcs_pkg::STEPS_PER_STAGE];
            end
        end
    end

    assign result = stage_reg[rmmcs_pkg::DIV_STAGES];

endmodule

// ===== hw/rtl/rgb_min_max_contrast_stretch_core.sv =====
// Top level of the RGB min/max contrast stretch core.
//
// The core maps each 16-bit red, green and blue sample into 8 bits through its own
// window [low, high]: a sample below low gives 0, otherwise the value is
// floor((sample - low) * 256 / (high - low)) saturated to 255, and an empty or
// inverted window sends every sample at or above low to 255. It accepts one pixel
// transaction every clock while the output side does not stall and delivers one
// result transaction per pixel, in order. Its six stages are the window compare
// stage, four divider stages that each retire two quotient bits with a restoring
// subtract, and the output stage that forms the final channel values and alpha.
// Every stage holds its own valid bit, so back pressure from the output stops only
// the stages that are full and bubbles are squeezed out. The registers are written
// through a simple write port and should only be changed while no pixel is in
// flight; frame_last repeats frame_end of the same pixel.
module rgb_min_max_contrast_stretch_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [rmmcs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [rmmcs_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [rmmcs_pkg::IN_BITS-1:0]        red_sample,
    input  logic [rmmcs_pkg::IN_BITS-1:0]        green_sample,
    input  logic [rmmcs_pkg::IN_BITS-1:0]        blue_sample,
    input  logic                                 frame_end,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [rmmcs_pkg::OUT_BITS-1:0]       red_out,
    output logic [rmmcs_pkg::OUT_BITS-1:0]       green_out,
    output logic [rmmcs_pkg::OUT_BITS-1:0]       blue_out,
    output logic [rmmcs_pkg::OUT_BITS-1:0]       alpha_out,
    output logic                                 frame_last
);

    localparam int LAST = rmmcs_pkg::PIPE_STAGES - 1;

    rmmcs_pkg::cfg_t  cfg;
    rmmcs_pkg::lane_t red_lane;
    rmmcs_pkg::lane_t green_lane;
    rmmcs_pkg::lane_t blue_lane;

    logic [LAST:0] valid_reg;
    logic [LAST:0] valid_next;
    logic [LAST:0] frame_reg;
    logic [LAST:0] frame_next;
    logic [LAST:0] stage_ready;

    rmmcs_pkg::pixel_t red_out_reg;
    rmmcs_pkg::pixel_t green_out_reg;
    rmmcs_pkg::pixel_t blue_out_reg;
    rmmcs_pkg::pixel_t alpha_out_reg;
    rmmcs_pkg::pixel_t red_out_next;
    rmmcs_pkg::pixel_t green_out_next;
    rmmcs_pkg::pixel_t blue_out_next;
    rmmcs_pkg::pixel_t alpha_out_next;

    rmmcs_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // A stage may load when it is empty or when its content moves on this cycle.
    always_comb
    begin
        stage_ready[LAST] = !valid_reg[LAST] || out_ready;
        for (int k = LAST - 1; k >= 0; k--)
        begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    // Valid bits and the frame marker shift along with the lane data.
    always_comb
    begin
        valid_next[0] = in_valid;
        frame_next[0] = frame_end;
        for (int k = 1; k <= LAST; k++)
        begin
            valid_next[k] = valid_reg[k-1];
            frame_next[k] = frame_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k <= LAST; k++)
            begin
                if (stage_ready[k])
                begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= LAST; k++)
        begin
            if (stage_ready[k])
            begin
                frame_reg[k] <= frame_next[k];
            end
        end
    end

    rmmcs_lane u_red_lane (
        .clk    (clk),
        .en     (stage_ready[LAST-1:0]),
        .sample (red_sample[rmmcs_pkg::SAMPLE_BITS-1:0]),
        .window (cfg.red),
        .result (red_lane)
    );

    rmmcs_lane u_green_lane (
        .clk    (clk),
        .en     (stage_ready[LAST-1:0]),
        .sample (green_sample[rmmcs_pkg::SAMPLE_BITS-1:0]),
        .window (cfg.green),
        .result (green_lane)
    );

    rmmcs_lane u_blue_lane (
        .clk    (clk),
        .en     (stage_ready[LAST-1:0]),
        .sample (blue_sample[rmmcs_pkg::SAMPLE_BITS-1:0]),
        .window (cfg.blue),
        .result (blue_lane)
    );

    // Output stage: resolve each lane to its channel value and derive alpha.
    // In thumbnail mode a pixel that is black in all three channels turns transparent.
    always_comb
    begin
        red_out_next   = rmmcs_pkg::lane_value(red_lane);
        green_out_next = rmmcs_pkg::lane_value(green_lane);
        blue_out_next  = rmmcs_pkg::lane_value(blue_lane);
        if (cfg.alpha_mode && ((red_out_next | green_out_next | blue_out_next) == '0))
        begin
            alpha_out_next = rmmcs_pkg::ALPHA_CLEAR;
        end
        else
        begin
            alpha_out_next = rmmcs_pkg::ALPHA_OPAQUE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[LAST])
        begin
            red_out_reg   <= red_out_next;
            green_out_reg <= green_out_next;
            blue_out_reg  <= blue_out_next;
            alpha_out_reg <= alpha_out_next;
        end
    end

    assign in_ready   = stage_ready[0];
    assign out_valid  = valid_reg[LAST];
    assign red_out    = red_out_reg;
    assign green_out  = green_out_reg;
    assign blue_out   = blue_out_reg;
    assign alpha_out  = alpha_out_reg;
    assign frame_last = frame_reg[LAST];

    // A stalled last divider stage must keep its transaction.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[LAST-1] && !stage_ready[LAST-1]) |=> valid_reg[LAST-1])
        else $error("stalled divider stage lost its transaction");

    // Alpha takes only its two legal codes.
    a_alpha_codes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (alpha_out == rmmcs_pkg::ALPHA_OPAQUE || alpha_out == rmmcs_pkg::ALPHA_CLEAR))
        else $error("alpha holds an illegal code");

    // A transparent pixel is black in every channel.
    a_clear_is_black: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && alpha_out == rmmcs_pkg::ALPHA_CLEAR)
            |-> (red_out == '0 && green_out == '0 && blue_out == '0))
        else $error("transparent pixel with nonzero channel");

    // A delivered result with nothing behind it leaves the output empty.
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !valid_reg[LAST-1]) |=> !out_valid)
        else $error("output repeated a transaction");

endmodule
